/* rtl/core/x86enc_pkg.sv */
// Package for the x86 instruction encoder: request modes, opcodes and the
// encoded-record type carried from front to back. No dependencies.
package x86enc_pkg;

  localparam int MAX_BYTES     = 7;
  localparam int LEN_W         = 3;
  localparam int QUEUE_DEPTH_DEF = 2;

  typedef logic [4:0] mode_t;

  localparam mode_t MODE_MOV       = 5'd0;
  localparam mode_t MODE_XCHG      = 5'd1;
  localparam mode_t MODE_POP       = 5'd2;
  localparam mode_t MODE_PUSH      = 5'd3;
  localparam mode_t MODE_XOR       = 5'd4;
  localparam mode_t MODE_MOVIMM_RAW = 5'd5;
  localparam mode_t MODE_MOVIMM    = 5'd6;
  localparam mode_t MODE_PUSHIMM   = 5'd7;
  localparam mode_t MODE_TEST      = 5'd8;
  localparam mode_t MODE_NEG       = 5'd9;
  localparam mode_t MODE_NOT       = 5'd10;
  localparam mode_t MODE_ADD       = 5'd11;
  localparam mode_t MODE_AND_IMM   = 5'd12;
  localparam mode_t MODE_OR_IMM    = 5'd13;
  localparam mode_t MODE_XOR_IMM   = 5'd14;
  localparam mode_t MODE_ADD_IMM   = 5'd15;
  localparam mode_t MODE_SUB_IMM   = 5'd16;
  localparam mode_t MODE_STORE     = 5'd17;
  localparam mode_t MODE_LOAD      = 5'd18;
  localparam mode_t MODE_CMP_IMM   = 5'd19;

  localparam logic [7:0] OPC_MOV_RM    = 8'h89;
  localparam logic [7:0] OPC_MOV_LOAD  = 8'h8B;
  localparam logic [7:0] OPC_XCHG      = 8'h87;
  localparam logic [7:0] OPC_XCHG_EAX  = 8'h90;
  localparam logic [7:0] OPC_POP       = 8'h58;
  localparam logic [7:0] OPC_PUSH      = 8'h50;
  localparam logic [7:0] OPC_XOR_RM    = 8'h31;
  localparam logic [7:0] OPC_ADD_RM    = 8'h01;
  localparam logic [7:0] OPC_MOV_IMM   = 8'hB8;
  localparam logic [7:0] OPC_PUSH_IMM32 = 8'h68;
  localparam logic [7:0] OPC_PUSH_IMM8 = 8'h6A;
  localparam logic [7:0] OPC_TEST      = 8'h85;
  localparam logic [7:0] OPC_GRP3      = 8'hF7;
  localparam logic [7:0] OPC_GRP1_IMM32 = 8'h81;
  localparam logic [7:0] OPC_GRP1_IMM8 = 8'h83;
  localparam logic [7:0] OPC_AND_EAX   = 8'h25;
  localparam logic [7:0] OPC_OR_EAX    = 8'h0D;
  localparam logic [7:0] OPC_XOR_EAX   = 8'h35;
  localparam logic [7:0] OPC_ADD_EAX   = 8'h05;
  localparam logic [7:0] OPC_SUB_EAX   = 8'h2D;
  localparam logic [7:0] OPC_CMP_EAX   = 8'h3D;
  localparam logic [7:0] SIB_ESP       = 8'h24;

  localparam logic [2:0] EXT_ADD = 3'd0;
  localparam logic [2:0] EXT_OR  = 3'd1;
  localparam logic [2:0] EXT_AND = 3'd4;
  localparam logic [2:0] EXT_SUB = 3'd5;
  localparam logic [2:0] EXT_XOR = 3'd6;
  localparam logic [2:0] EXT_CMP = 3'd7;
  localparam logic [2:0] EXT_NOT = 3'd2;
  localparam logic [2:0] EXT_NEG = 3'd3;

  localparam logic [2:0] REG_EAX = 3'd0;
  localparam logic [2:0] REG_ESP = 3'd4;
  localparam logic [2:0] REG_EBP = 3'd5;

  localparam logic [1:0] MD_IND   = 2'b00;
  localparam logic [1:0] MD_DISP8 = 2'b01;
  localparam logic [1:0] MD_DISP32 = 2'b10;
  localparam logic [1:0] MD_REG   = 2'b11;

  typedef struct packed {
    logic [MAX_BYTES-1:0][7:0] bytes;
    logic [LEN_W-1:0]          len;
  } enc_t;

  typedef struct packed {
    logic full;
    logic nonempty;
  } qstat_t;

  function automatic logic [7:0] modrm(input logic [1:0] md, input logic [2:0] r,
                                       input logic [2:0] rm);
    return {md, r, rm};
  endfunction

endpackage

/* rtl/core/x86enc_if.sv */
// Valid/ready channel interfaces for the encoder's request and byte streams.
// Depends on nothing.
interface x86enc_req_if (input logic clk);
  logic              valid;
  logic              ready;
  logic [4:0]        mode;
  logic [2:0]        first_reg;
  logic [2:0]        second_reg;
  logic signed [31:0] value;

  modport source (output valid, mode, first_reg, second_reg, value, input ready);
  modport sink   (input valid, mode, first_reg, second_reg, value, output ready);
endinterface

interface x86enc_code_if (input logic clk);
  logic       valid;
  logic       ready;
  logic [7:0] code_byte;
  logic       last_byte;

  modport source (output valid, code_byte, last_byte, input ready);
  modport sink   (input valid, code_byte, last_byte, output ready);
endinterface

/* rtl/core/x86enc_front.sv */
// Front end: accepts a request and builds its complete byte encoding.
// Depends on x86enc_pkg and x86enc_req_if.
module x86enc_front
  import x86enc_pkg::*;
(
  x86enc_req_if.sink req,
  input  qstat_t     qstat,
  output logic       push,
  output enc_t       rec
);

  logic [31:0] v;
  logic [2:0]  a;
  logic [2:0]  b;
  logic        fits;
  logic        ri_en;
  logic [2:0]  ri_ext;
  logic [7:0]  ri_acc;
  logic        mem_en;
  logic [7:0]  m_opc;
  logic [2:0]  m_reg;
  logic [2:0]  m_base;
  logic [1:0]  m_md;

  assign v    = req.value;
  assign a    = req.first_reg;
  assign b    = req.second_reg;
  assign fits = (v[31:7] == '0) || (v[31:7] == '1);

  always_comb begin
    rec        = '0;
    ri_en      = 1'b0;
    ri_ext     = EXT_ADD;
    ri_acc     = OPC_ADD_EAX;
    mem_en     = 1'b0;
    m_opc      = OPC_MOV_RM;
    m_reg      = b;
    m_base     = a;
    unique case (req.mode)
      MODE_MOV: begin
        rec.bytes[0] = OPC_MOV_RM;
        rec.bytes[1] = modrm(MD_REG, b, a);
        rec.len      = 3'd2;
      end
      MODE_XCHG: begin
        if (a == REG_EAX || b == REG_EAX) begin
          rec.bytes[0] = OPC_XCHG_EAX | {5'd0, a | b};
          rec.len      = 3'd1;
        end else begin
          rec.bytes[0] = OPC_XCHG;
          rec.bytes[1] = modrm(MD_REG, b, a);
          rec.len      = 3'd2;
        end
      end
      MODE_POP: begin
        rec.bytes[0] = OPC_POP | {5'd0, a};
        rec.len      = 3'd1;
      end
      MODE_PUSH: begin
        rec.bytes[0] = OPC_PUSH | {5'd0, a};
        rec.len      = 3'd1;
      end
      MODE_XOR: begin
        rec.bytes[0] = OPC_XOR_RM;
        rec.bytes[1] = modrm(MD_REG, b, a);
        rec.len      = 3'd2;
      end
      MODE_MOVIMM_RAW, MODE_MOVIMM: begin
        if (req.mode == MODE_MOVIMM && v == '0) begin
          rec.bytes[0] = OPC_XOR_RM;
          rec.bytes[1] = modrm(MD_REG, a, a);
          rec.len      = 3'd2;
        end else begin
          rec.bytes[0]   = OPC_MOV_IMM | {5'd0, a};
          rec.bytes[4:1] = v;
          rec.len        = 3'd5;
        end
      end
      MODE_PUSHIMM: begin
        if (fits) begin
          rec.bytes[0] = OPC_PUSH_IMM8;
          rec.bytes[1] = v[7:0];
          rec.len      = 3'd2;
        end else begin
          rec.bytes[0]   = OPC_PUSH_IMM32;
          rec.bytes[4:1] = v;
          rec.len        = 3'd5;
        end
      end
      MODE_TEST: begin
        rec.bytes[0] = OPC_TEST;
        rec.bytes[1] = modrm(MD_REG, a, a);
        rec.len      = 3'd2;
      end
      MODE_NEG: begin
        rec.bytes[0] = OPC_GRP3;
        rec.bytes[1] = modrm(MD_REG, EXT_NEG, a);
        rec.len      = 3'd2;
      end
      MODE_NOT: begin
        rec.bytes[0] = OPC_GRP3;
        rec.bytes[1] = modrm(MD_REG, EXT_NOT, a);
        rec.len      = 3'd2;
      end
      MODE_ADD: begin
        rec.bytes[0] = OPC_ADD_RM;
        rec.bytes[1] = modrm(MD_REG, b, a);
        rec.len      = 3'd2;
      end
      MODE_AND_IMM: begin
        ri_en  = 1'b1;
        ri_ext = EXT_AND;
        ri_acc = OPC_AND_EAX;
      end
      MODE_OR_IMM: begin
        ri_en  = 1'b1;
        ri_ext = EXT_OR;
        ri_acc = OPC_OR_EAX;
      end
      MODE_XOR_IMM: begin
        ri_en  = 1'b1;
        ri_ext = EXT_XOR;
        ri_acc = OPC_XOR_EAX;
      end
      MODE_ADD_IMM: begin
        ri_en  = 1'b1;
        ri_ext = EXT_ADD;
        ri_acc = OPC_ADD_EAX;
      end
      MODE_SUB_IMM: begin
        ri_en  = 1'b1;
        ri_ext = EXT_SUB;
        ri_acc = OPC_SUB_EAX;
      end
      MODE_CMP_IMM: begin
        ri_en  = 1'b1;
        ri_ext = EXT_CMP;
        ri_acc = OPC_CMP_EAX;
      end
      MODE_STORE: begin
        mem_en = 1'b1;
        m_opc  = OPC_MOV_RM;
        m_reg  = b;
        m_base = a;
      end
      MODE_LOAD: begin
        mem_en = 1'b1;
        m_opc  = OPC_MOV_LOAD;
        m_reg  = a;
        m_base = b;
      end
      default: rec.len = '0;
    endcase

    if (ri_en) begin
      if (a == REG_EAX && !fits) begin
        rec.bytes[0]   = ri_acc;
        rec.bytes[4:1] = v;
        rec.len        = 3'd5;
      end else if (fits) begin
        rec.bytes[0] = OPC_GRP1_IMM8;
        rec.bytes[1] = modrm(MD_REG, ri_ext, a);
        rec.bytes[2] = v[7:0];
        rec.len      = 3'd3;
      end else begin
        rec.bytes[0]   = OPC_GRP1_IMM32;
        rec.bytes[1]   = modrm(MD_REG, ri_ext, a);
        rec.bytes[5:2] = v;
        rec.len        = 3'd6;
      end
    end

    m_md = (v == '0 && m_base != REG_EBP) ? MD_IND : (fits ? MD_DISP8 : MD_DISP32);
    if (mem_en) begin
      rec.bytes[0] = m_opc;
      rec.bytes[1] = modrm(m_md, m_reg, m_base);
      if (m_base == REG_ESP) begin
        rec.bytes[2] = SIB_ESP;
        unique case (m_md)
          MD_DISP8: begin
            rec.bytes[3] = v[7:0];
            rec.len      = 3'd4;
          end
          MD_DISP32: begin
            rec.bytes[6:3] = v;
            rec.len        = 3'd7;
          end
          default: rec.len = 3'd3;
        endcase
      end else begin
        unique case (m_md)
          MD_DISP8: begin
            rec.bytes[2] = v[7:0];
            rec.len      = 3'd3;
          end
          MD_DISP32: begin
            rec.bytes[5:2] = v;
            rec.len        = 3'd6;
          end
          default: rec.len = 3'd2;
        endcase
      end
    end
  end

  assign req.ready = !qstat.full;
  assign push      = req.valid && !qstat.full && (rec.len != '0);

endmodule

/* rtl/core/x86enc_queue.sv */
// Short FIFO of encoded records between front and back.
// Depends on x86enc_pkg.
module x86enc_queue
  import x86enc_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  enc_t   wr_rec,
  input  logic   pop,
  output enc_t   rd_rec,
  output qstat_t qstat
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  enc_t             slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_rec;
    end
  end

  assign rd_rec         = slots[rd_ptr];
  assign qstat.full     = (count == CNT_FULL);
  assign qstat.nonempty = (count != '0);

endmodule

/* rtl/core/x86enc_back.sv */
// Back end: holds one encoded record and sends it out a byte per transfer.
// Depends on x86enc_pkg and x86enc_code_if.
module x86enc_back
  import x86enc_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  qstat_t qstat,
  input  enc_t   rd_rec,
  output logic   pop,
  x86enc_code_if.source code
);

  logic             cur_valid;
  enc_t             cur;
  logic [LEN_W-1:0] idx;
  logic             is_last;
  logic             xfer;

  assign is_last = (idx == cur.len - 1'b1);
  assign xfer    = cur_valid && code.ready;
  assign pop     = qstat.nonempty && (!cur_valid || (xfer && is_last));

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= '0;
    end else if (pop) begin
      cur_valid <= 1'b1;
      idx       <= '0;
    end else if (xfer) begin
      if (is_last) begin
        cur_valid <= 1'b0;
      end else begin
        idx <= idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= rd_rec;
    end
  end

  assign code.valid     = cur_valid;
  assign code.code_byte = cur.bytes[idx];
  assign code.last_byte = is_last;

endmodule

/* rtl/core/x86_instruction_encoder_top.sv */
// Top level of the 32-bit x86 instruction encoder: front, queue and back.
// Depends on x86enc_pkg, the channel interfaces and the three submodules.
//
//  channel | role   | payload                                  | per transfer
//  req     | sink   | mode, first_reg, second_reg, value       | one request
//  code    | source | code_byte, last_byte                     | one byte
//
// A request is encoded in the cycle it is taken and queued; the back end
// sends one byte per cycle while code is ready, over the single byte-wide
// output, 1 to 7 bytes per instruction. Unknown modes are taken and
// produce nothing. Requests keep being taken while the queue has room,
// also while code stalls. Reset clears the queue and the byte sender.
module x86_instruction_encoder_top
  import x86enc_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input logic clk,
  input logic rst,
  x86enc_req_if.sink    req,
  x86enc_code_if.source code
);

  qstat_t qstat;
  logic   push;
  logic   pop;
  enc_t   wr_rec;
  enc_t   rd_rec;

  x86enc_front u_front (
    .req   (req),
    .qstat (qstat),
    .push  (push),
    .rec   (wr_rec)
  );

  x86enc_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_rec (wr_rec),
    .pop    (pop),
    .rd_rec (rd_rec),
    .qstat  (qstat)
  );

  x86enc_back u_back (
    .clk    (clk),
    .rst    (rst),
    .qstat  (qstat),
    .rd_rec (rd_rec),
    .pop    (pop),
    .code   (code)
  );

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    push |-> !qstat.full)
    else $error("push into full queue");

  a_pop_data: assert property (@(posedge clk) disable iff (rst)
    pop |-> qstat.nonempty)
    else $error("pop from empty queue");

  a_push_len: assert property (@(posedge clk) disable iff (rst)
    push |-> (wr_rec.len != '0) && (wr_rec.len <= LEN_W'(MAX_BYTES)))
    else $error("queued record with bad length");

  a_cont: assert property (@(posedge clk) disable iff (rst)
    code.valid && code.ready && !code.last_byte |=> code.valid)
    else $error("instruction cut short");

endmodule
